// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define URX_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("urx: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define URX_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("urx: next-cycle check failed");

`endif

// ===== src/urx_pkg.sv =====
package urx_pkg;

  // Payload size limits
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int MAX_PAYLOAD_TOP = 64;
  localparam int DESC_LEN_W      = $clog2(MAX_PAYLOAD_TOP + 1);

  // Result field widths
  localparam int LEN_OUT_W = 6;
  localparam int IDX_OUT_W = 5;

  // Frame descriptor queue depth
  localparam int DESC_DEPTH = 2;
  // Result queue depth
  localparam int OUT_DEPTH  = 4;

  // CRC-16 (reflected) constants
  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Configuration register reset values and indexes
  localparam logic [7:0] HEAD_RESET    = 8'h55;
  localparam logic [7:0] VERSION_RESET = 8'h01;
  localparam int         CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_VERSION,
    PH_CMD,
    PH_SEQ,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // One finished frame handed from the parser to the emitter
  typedef struct packed {
    logic                  good;
    logic [7:0]            cmd;
    logic [7:0]            seq;
    logic [DESC_LEN_W-1:0] len;
  } frame_desc_t;

  // One result word
  typedef struct packed {
    logic                 crc_good;
    logic [7:0]           frame_cmd;
    logic [7:0]           frame_seq;
    logic [LEN_OUT_W-1:0] frame_length;
    logic                 has_byte;
    logic [IDX_OUT_W-1:0] byte_index;
    logic [7:0]           payload_value;
    logic                 last;
  } result_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/urx_front.sv =====
module urx_front #(
  parameter int MAX_PAYLOAD = urx_pkg::MAX_PAYLOAD_DEF,
  parameter int LW          = $clog2(MAX_PAYLOAD + 1),
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [urx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_push,
  input  logic [7:0]                     in_rx_byte,
  output logic                           in_full,
  input  logic                           back_busy,
  input  logic                           desc_full,
  output logic                           desc_push,
  output urx_pkg::frame_desc_t           desc,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_addr,
  output logic [7:0]                     mem_wdata
);

  urx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  head_r, version_r;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] fill_inc;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_step;
  logic        accept;
  logic        too_long;
  logic        crc_match;

  assign accept    = in_push && !in_full;
  assign too_long  = in_rx_byte > 8'(MAX_PAYLOAD);
  assign fill_inc  = LW'(fill_r + 1'b1);
  assign crc_step  = urx_pkg::crc16_byte(crc_r, in_rx_byte);
  assign crc_match = ({in_rx_byte, crc_lo_r} == crc_r);

  // Hold the payload while the back end still reads it; hold the CRC byte on a full queue
  assign in_full = ((phase_r == urx_pkg::PH_PAYLOAD) && back_busy) ||
                   ((phase_r == urx_pkg::PH_CRC_HI) && desc_full);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= urx_pkg::HEAD_RESET;
      version_r <= urx_pkg::VERSION_RESET;
    end else if (cfg_we) begin
      if (cfg_index == urx_pkg::CFG_HEAD) begin
        head_r <= cfg_wdata;
      end
      if (cfg_index == urx_pkg::CFG_VERSION) begin
        version_r <= cfg_wdata;
      end
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        urx_pkg::PH_HUNT: begin
          if (in_rx_byte == head_r) phase_nxt = urx_pkg::PH_VERSION;
        end
        urx_pkg::PH_VERSION: begin
          phase_nxt = (in_rx_byte == version_r) ? urx_pkg::PH_CMD : urx_pkg::PH_HUNT;
        end
        urx_pkg::PH_CMD:    phase_nxt = urx_pkg::PH_SEQ;
        urx_pkg::PH_SEQ:    phase_nxt = urx_pkg::PH_LENGTH;
        urx_pkg::PH_LENGTH: begin
          if (too_long) begin
            phase_nxt = urx_pkg::PH_HUNT;
          end else if (in_rx_byte == 8'd0) begin
            phase_nxt = urx_pkg::PH_CRC_LO;
          end else begin
            phase_nxt = urx_pkg::PH_PAYLOAD;
          end
        end
        urx_pkg::PH_PAYLOAD: begin
          if (fill_inc >= len_r) phase_nxt = urx_pkg::PH_CRC_LO;
        end
        urx_pkg::PH_CRC_LO: phase_nxt = urx_pkg::PH_CRC_HI;
        urx_pkg::PH_CRC_HI: phase_nxt = urx_pkg::PH_HUNT;
        default:            phase_nxt = urx_pkg::PH_HUNT;
      endcase
    end
  end

  // Datapath updates, payload writes and frame hand-off
  always_comb begin
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    fill_nxt   = fill_r;
    crc_lo_nxt = crc_lo_r;
    crc_nxt    = crc_r;
    mem_we     = 1'b0;
    mem_addr   = fill_r[AW-1:0];
    mem_wdata  = in_rx_byte;
    desc_push  = 1'b0;
    desc.good  = crc_match;
    desc.cmd   = cmd_r;
    desc.seq   = seq_r;
    desc.len   = urx_pkg::DESC_LEN_W'(len_r);
    if (accept) begin
      unique case (phase_r)
        urx_pkg::PH_HUNT: begin
          if (in_rx_byte == head_r) crc_nxt = urx_pkg::CRC_START;
        end
        urx_pkg::PH_VERSION: begin
          if (in_rx_byte == version_r) crc_nxt = crc_step;
        end
        urx_pkg::PH_CMD: begin
          cmd_nxt = in_rx_byte;
          crc_nxt = crc_step;
        end
        urx_pkg::PH_SEQ: begin
          seq_nxt = in_rx_byte;
          crc_nxt = crc_step;
        end
        urx_pkg::PH_LENGTH: begin
          if (!too_long) begin
            len_nxt  = LW'(in_rx_byte);
            crc_nxt  = crc_step;
            fill_nxt = '0;
          end
        end
        urx_pkg::PH_PAYLOAD: begin
          mem_we   = 1'b1;
          crc_nxt  = crc_step;
          fill_nxt = fill_inc;
        end
        urx_pkg::PH_CRC_LO: crc_lo_nxt = in_rx_byte;
        urx_pkg::PH_CRC_HI: begin
          desc_push = 1'b1;
          fill_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= urx_pkg::PH_HUNT;
      cmd_r    <= '0;
      seq_r    <= '0;
      len_r    <= '0;
      fill_r   <= '0;
      crc_lo_r <= '0;
      crc_r    <= urx_pkg::CRC_START;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      fill_r   <= fill_nxt;
      crc_lo_r <= crc_lo_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule

// ===== src/urx_desc_fifo.sv =====
module urx_desc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  urx_pkg::frame_desc_t din,
  output logic                 full,
  input  logic                 pop,
  output urx_pkg::frame_desc_t dout,
  output logic                 empty
);

  localparam int PW = (urx_pkg::DESC_DEPTH > 1) ? $clog2(urx_pkg::DESC_DEPTH) : 1;
  localparam int CW = $clog2(urx_pkg::DESC_DEPTH + 1);

  urx_pkg::frame_desc_t slot_r [urx_pkg::DESC_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(urx_pkg::DESC_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(urx_pkg::DESC_DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(urx_pkg::DESC_DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== src/urx_back.sv =====
module urx_back #(
  parameter int MAX_PAYLOAD = urx_pkg::MAX_PAYLOAD_DEF,
  parameter int LW          = $clog2(MAX_PAYLOAD + 1),
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 desc_valid,
  input  urx_pkg::frame_desc_t desc,
  output logic                 desc_pop,
  output logic                 busy,
  input  logic                 mem_we,
  input  logic [AW-1:0]        mem_addr,
  input  logic [7:0]           mem_wdata,
  input  logic                 out_pop,
  output logic                 out_empty,
  output urx_pkg::result_t     out_res
);

  localparam int OPW = $clog2(urx_pkg::OUT_DEPTH);
  localparam int OCW = $clog2(urx_pkg::OUT_DEPTH + 1);

  // Payload memory
  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] mem_q_r;

  // Emitter
  logic                 em_active_r, em_active_nxt;
  urx_pkg::frame_desc_t em_desc_r, em_desc_nxt;
  logic [LW-1:0]        em_idx_r, em_idx_nxt;
  logic [LW-1:0]        em_total;
  logic [LW-1:0]        em_idx_inc;
  logic                 em_has;
  logic                 em_last;
  logic                 issue;

  // Read stage
  logic                 rd_vld_r;
  urx_pkg::result_t     rd_meta_r, rd_meta_nxt;
  urx_pkg::result_t     rd_res;

  // Result queue
  urx_pkg::result_t     oq_r [urx_pkg::OUT_DEPTH];
  logic [OPW-1:0]       oq_wr_r, oq_rd_r;
  logic [OCW-1:0]       oq_cnt_r, oq_cnt_nxt;
  logic [OCW:0]         oq_claim;
  logic                 oq_pop;

  // Frame run length: payload bytes for a good non-empty frame, else one word
  assign em_has     = em_desc_r.good && (em_desc_r.len != '0);
  assign em_total   = em_has ? LW'(em_desc_r.len) : LW'(1);
  assign em_idx_inc = LW'(em_idx_r + 1'b1);
  assign em_last    = (em_idx_inc == em_total);

  // Issue a read only when the result queue has room for everything in flight
  assign oq_claim = (OCW + 1)'(oq_cnt_r) + (OCW + 1)'(rd_vld_r);
  assign issue    = em_active_r && (oq_claim < (OCW + 1)'(urx_pkg::OUT_DEPTH));

  // Load the next frame when idle or on the last word of the current one
  assign desc_pop = desc_valid && (!em_active_r || (issue && em_last));
  assign busy     = em_active_r;

  always_comb begin
    em_active_nxt = em_active_r;
    em_desc_nxt   = em_desc_r;
    em_idx_nxt    = em_idx_r;
    if (issue) begin
      em_idx_nxt = em_idx_inc;
      if (em_last) em_active_nxt = 1'b0;
    end
    if (desc_pop) begin
      em_active_nxt = 1'b1;
      em_desc_nxt   = desc;
      em_idx_nxt    = '0;
    end
  end

  // Result word without the payload byte, zeroed on a CRC mismatch
  always_comb begin
    rd_meta_nxt.crc_good      = em_desc_r.good;
    rd_meta_nxt.frame_cmd     = em_desc_r.good ? em_desc_r.cmd : 8'd0;
    rd_meta_nxt.frame_seq     = em_desc_r.good ? em_desc_r.seq : 8'd0;
    rd_meta_nxt.frame_length  = em_desc_r.good ? urx_pkg::LEN_OUT_W'(em_desc_r.len) : '0;
    rd_meta_nxt.has_byte      = em_has;
    rd_meta_nxt.byte_index    = em_has ? urx_pkg::IDX_OUT_W'(em_idx_r) : '0;
    rd_meta_nxt.payload_value = 8'd0;
    rd_meta_nxt.last          = em_last;
  end

  always_comb begin
    rd_res               = rd_meta_r;
    rd_res.payload_value = rd_meta_r.has_byte ? mem_q_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_active_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      em_active_r <= em_active_nxt;
      rd_vld_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    em_desc_r <= em_desc_nxt;
    em_idx_r  <= em_idx_nxt;
    if (issue) begin
      rd_meta_r <= rd_meta_nxt;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q_r <= mem[em_idx_r[AW-1:0]];
    end
  end

  // Result queue
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_r[oq_rd_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (rd_vld_r && !oq_pop) begin
      oq_cnt_nxt = OCW'(oq_cnt_r + 1'b1);
    end else if (oq_pop && !rd_vld_r) begin
      oq_cnt_nxt = OCW'(oq_cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (rd_vld_r) oq_wr_r <= OPW'(oq_wr_r + 1'b1);
      if (oq_pop)   oq_rd_r <= OPW'(oq_rd_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      oq_r[oq_wr_r] <= rd_res;
    end
  end

endmodule

// ===== src/uart_frame_receiver_crc16_top.sv =====
// Serial frame receiver with CRC-16 check.
// Input: one received byte per word on in_rx_byte, taken when in_push is high
// and in_full is low. Frames are head, version, cmd, seq, length, payload,
// crc low, crc high; the CRC (reflected, poly 0xA001, start 0xFFFF) covers
// version through payload. Results leave through a queue: a word is on the
// out_ ports while out_empty is low and is taken when out_pop is high.
// A good frame yields one word per payload byte (one word if empty); a bad
// CRC yields one error word with crc_good low. Bad version or an oversized
// length drops the frame silently.
// Throughput: one byte per cycle while in_full is low. Payload bytes of a new frame
// wait while the previous frame's payload is still being read from the single payload
// memory. The first result word of a frame passes through the descriptor queue,
// the emitter register and the read stage before it enters the result queue.
// A stalled receiver fills the 4-word result queue, then input stops at the next
// payload byte, or at a CRC high byte once the 2-frame descriptor queue is full.
// cfg_we writes head value (index 0) or version value (index 1) at once.
// Reset (synchronous, rst_n low) returns to hunting, empties both queues and
// restores head 0x55 and version 0x01; no memory clearing is needed.
module uart_frame_receiver_crc16_top #(
  parameter int MAX_PAYLOAD = urx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_crc_good,
  output logic [7:0]                    out_frame_cmd,
  output logic [7:0]                    out_frame_seq,
  output logic [urx_pkg::LEN_OUT_W-1:0] out_frame_length,
  output logic                          out_has_byte,
  output logic [urx_pkg::IDX_OUT_W-1:0] out_byte_index,
  output logic [7:0]                    out_payload_value,
  output logic                          out_last
);

  `include "assert_macros.svh"

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic                 desc_push, desc_full, desc_pop, desc_empty;
  urx_pkg::frame_desc_t desc_in, desc_out;
  logic                 em_busy, back_busy;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [7:0]           mem_wdata;
  urx_pkg::result_t     out_res;

  // The payload memory is in use while any frame is queued or being read out
  assign back_busy = !desc_empty || em_busy;

  urx_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .LW          (LW),
    .AW          (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .back_busy  (back_busy),
    .desc_full  (desc_full),
    .desc_push  (desc_push),
    .desc       (desc_in),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  urx_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc_in),
    .full  (desc_full),
    .pop   (desc_pop),
    .dout  (desc_out),
    .empty (desc_empty)
  );

  urx_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .LW          (LW),
    .AW          (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (!desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .busy       (em_busy),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_res    (out_res)
  );

  // Split the result word onto the ports
  assign out_crc_good      = out_res.crc_good;
  assign out_frame_cmd     = out_res.frame_cmd;
  assign out_frame_seq     = out_res.frame_seq;
  assign out_frame_length  = out_res.frame_length;
  assign out_has_byte      = out_res.has_byte;
  assign out_byte_index    = out_res.byte_index;
  assign out_payload_value = out_res.payload_value;
  assign out_last          = out_res.last;

  // Payload is never overwritten while a frame still needs it
  `URX_ASSERT_IMP(a_mem_wr_idle, clk, rst_n, mem_we, !back_busy)
  // A frame is never handed off into a full descriptor queue
  `URX_ASSERT_IMP(a_desc_no_overflow, clk, rst_n, desc_push, !desc_full)
  // A handed-off frame is visible to the back end on the next cycle
  `URX_ASSERT_NXT(a_desc_visible, clk, rst_n, desc_push, !desc_empty)

endmodule

// ===== bench/uart_frame_receiver_crc16_top_test.sv =====
module uart_frame_receiver_crc16_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  // Longest payload readout plus the emitter pipeline, with margin
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  // Watchdog limit, set far above the length of a correct run
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_CAP     = 40;
  // Random bytes sent under each register setting
  localparam int TRAFFIC_BYTES = 20;

  typedef enum logic [1:0] {
    POP_EVERY,
    POP_COIN,
    POP_BEAT
  } pop_style_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index = urx_pkg::CFG_HEAD;
  logic [7:0]                    cfg_wdata = 8'h00;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic [7:0]                    in_rx_byte = 8'h00;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic                          out_crc_good;
  logic [7:0]                    out_frame_cmd;
  logic [7:0]                    out_frame_seq;
  logic [urx_pkg::LEN_OUT_W-1:0] out_frame_length;
  logic                          out_has_byte;
  logic [urx_pkg::IDX_OUT_W-1:0] out_byte_index;
  logic [7:0]                    out_payload_value;
  logic                          out_last;

  // Parser shadow: register copies, frame fields and running CRC
  logic [7:0]       cur_head = urx_pkg::HEAD_RESET;
  logic [7:0]       cur_version = urx_pkg::VERSION_RESET;
  urx_pkg::phase_t  parse_phase = urx_pkg::PH_HUNT;
  logic [7:0]       cmd_seen = 8'h00;
  logic [7:0]       seq_seen = 8'h00;
  logic [5:0]       len_seen = 6'd0;
  logic [7:0]       crc_lo_seen = 8'h00;
  logic [15:0]      crc_acc = urx_pkg::CRC_START;
  int               fill_pos = 0;
  logic [7:0]       payload_copy [urx_pkg::MAX_PAYLOAD_DEF];
  urx_pkg::result_t frame_words_due [$];

  // Traffic shaping
  bit          sender_gaps = 1'b1;
  int          burst_left = 0;
  int          bytes_sent = 0;
  pop_style_t  pop_style = POP_BEAT;
  int          pop_beat = 0;
  bit          hold_req = 1'b0;
  logic        rx_hold = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;

  uart_frame_receiver_crc16_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_crc_good     (out_crc_good),
    .out_frame_cmd    (out_frame_cmd),
    .out_frame_seq    (out_frame_seq),
    .out_frame_length (out_frame_length),
    .out_has_byte     (out_has_byte),
    .out_byte_index   (out_byte_index),
    .out_payload_value(out_payload_value),
    .out_last         (out_last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Bit-serial reflected CRC-16, LSB of the data first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ urx_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // Error words carry zeros in every frame field
  function automatic urx_pkg::result_t make_word(input logic good, input logic has,
                                                 input int idx, input logic [7:0] val,
                                                 input logic fin);
    urx_pkg::result_t w;
    w.crc_good      = good;
    w.frame_cmd     = good ? cmd_seen : 8'h00;
    w.frame_seq     = good ? seq_seen : 8'h00;
    w.frame_length  = good ? len_seen : '0;
    w.has_byte      = has;
    w.byte_index    = idx[urx_pkg::IDX_OUT_W-1:0];
    w.payload_value = val;
    w.last          = fin;
    return w;
  endfunction

  // Advance the parser shadow by one byte and queue the words it releases
  task automatic parse_rx_byte(input logic [7:0] b);
    case (parse_phase)
      urx_pkg::PH_HUNT: begin
        if (b == cur_head) begin
          crc_acc = urx_pkg::CRC_START;
          parse_phase = urx_pkg::PH_VERSION;
        end
      end
      urx_pkg::PH_VERSION: begin
        // a wrong version byte is dropped, never rechecked as a head
        if (b == cur_version) begin
          crc_acc = crc_fold(crc_acc, b);
          parse_phase = urx_pkg::PH_CMD;
        end else begin
          parse_phase = urx_pkg::PH_HUNT;
        end
      end
      urx_pkg::PH_CMD: begin
        cmd_seen = b;
        crc_acc = crc_fold(crc_acc, b);
        parse_phase = urx_pkg::PH_SEQ;
      end
      urx_pkg::PH_SEQ: begin
        seq_seen = b;
        crc_acc = crc_fold(crc_acc, b);
        parse_phase = urx_pkg::PH_LENGTH;
      end
      urx_pkg::PH_LENGTH: begin
        if (b > urx_pkg::MAX_PAYLOAD_DEF) begin
          parse_phase = urx_pkg::PH_HUNT;
        end else begin
          len_seen = b[5:0];
          crc_acc = crc_fold(crc_acc, b);
          fill_pos = 0;
          parse_phase = (b == 8'd0) ? urx_pkg::PH_CRC_LO : urx_pkg::PH_PAYLOAD;
        end
      end
      urx_pkg::PH_PAYLOAD: begin
        payload_copy[fill_pos] = b;
        crc_acc = crc_fold(crc_acc, b);
        fill_pos++;
        if (fill_pos >= len_seen) begin
          parse_phase = urx_pkg::PH_CRC_LO;
        end
      end
      urx_pkg::PH_CRC_LO: begin
        crc_lo_seen = b;
        parse_phase = urx_pkg::PH_CRC_HI;
      end
      default: begin
        if ({b, crc_lo_seen} != crc_acc) begin
          frame_words_due.push_back(make_word(1'b0, 1'b0, 0, 8'h00, 1'b1));
        end else if (len_seen == 6'd0) begin
          frame_words_due.push_back(make_word(1'b1, 1'b0, 0, 8'h00, 1'b1));
        end else begin
          for (int i = 0; i < len_seen; i++) begin
            frame_words_due.push_back(make_word(1'b1, 1'b1, i, payload_copy[i],
                                                i == len_seen - 1));
          end
        end
        fill_pos = 0;
        parse_phase = urx_pkg::PH_HUNT;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic compare_result_word();
    urx_pkg::result_t want;
    if (frame_words_due.size() == 0) begin
      report_mismatch($sformatf("word with no frame due (cmd 0x%0h idx %0d)",
                                out_frame_cmd, out_byte_index));
    end else begin
      want = frame_words_due.pop_front();
      check_field("crc_good", out_crc_good, want.crc_good);
      check_field("frame_cmd", out_frame_cmd, want.frame_cmd);
      check_field("frame_seq", out_frame_seq, want.frame_seq);
      check_field("frame_length", out_frame_length, want.frame_length);
      check_field("has_byte", out_has_byte, want.has_byte);
      check_field("byte_index", out_byte_index, want.byte_index);
      check_field("payload_value", out_payload_value, want.payload_value);
      check_field("last", out_last, want.last);
    end
  endtask

  // Take result words and pick the next pop from the current stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        compare_result_word();
      end
      pop_beat++;
      case (pop_style)
        POP_EVERY: out_pop <= !rx_hold;
        POP_COIN:  out_pop <= !rx_hold && ($urandom_range(0, 3) != 0);
        default:   out_pop <= !rx_hold && ((pop_beat % 7) >= 3);
      endcase
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte and hold it until taken; push stays high on return
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      in_push <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop push, wait for every due word, then let the parser settle
  task automatic wait_drained();
    in_push <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; only called with the block drained
  task automatic set_registers(input logic [7:0] head_v, input logic [7:0] ver_v);
    cfg_we <= 1'b1;
    cfg_index <= urx_pkg::CFG_HEAD;
    cfg_wdata <= head_v;
    @(posedge clk);
    cur_head = head_v;
    cfg_index <= urx_pkg::CFG_VERSION;
    cfg_wdata <= ver_v;
    @(posedge clk);
    cur_version = ver_v;
    cfg_we <= 1'b0;
  endtask

  // Full frame with random payload; optionally spoil one CRC bit
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] seq, input int len,
                            input bit crc_ok);
    logic [7:0]  frame_bytes [$];
    logic [15:0] c;
    frame_bytes = {cur_version, cmd, seq, 8'(len)};
    for (int i = 0; i < len; i++) begin
      frame_bytes.push_back(8'($urandom));
    end
    c = urx_pkg::CRC_START;
    foreach (frame_bytes[i]) begin
      c = crc_fold(c, frame_bytes[i]);
    end
    if (!crc_ok) begin
      c ^= 16'(1 << $urandom_range(0, 15));
    end
    send_byte(cur_head);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic send_oversized(input logic [7:0] len_byte);
    send_byte(cur_head);
    send_byte(cur_version);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len_byte);
  endtask

  // Mostly well-formed frames, the rest broken frames and line noise
  task automatic run_traffic(input int n_bytes);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] v;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 19);
      len = (len < 12) ? $urandom_range(0, 4) :
            (len < 17) ? $urandom_range(5, 15) :
                         $urandom_range(16, urx_pkg::MAX_PAYLOAD_DEF);
      if (pick < 68) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b1);
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b0);
      end else if (pick < 87) begin
        // wrong version byte, sometimes the head value itself
        v = cur_version ^ 8'($urandom_range(1, 255));
        if (pick < 83 && cur_head != cur_version) begin
          v = cur_head;
        end
        send_byte(cur_head);
        send_byte(v);
      end else if (pick < 93) begin
        send_oversized(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(33, 254)));
      end else begin
        // noise, mostly clear of the head value
        repeat ($urandom_range(1, 4)) begin
          v = 8'($urandom);
          if (v == cur_head && $urandom_range(0, 3) != 0) begin
            v = ~v;
          end
          send_byte(v);
        end
      end
    end
  endtask

  // Head, then the head again as version: back to hunting, then a stray version
  task automatic test_version_mismatch();
    send_byte(cur_head);
    send_byte(cur_head);
    send_byte(cur_version);
    wait_drained();
  endtask

  task automatic test_empty_frame();
    send_frame(8'h00, 8'hFF, 0, 1'b1);
    wait_drained();
  endtask

  task automatic test_oversized_length();
    send_oversized(8'(urx_pkg::MAX_PAYLOAD_DEF + 1));
    wait_drained();
  endtask

  task automatic test_bad_crc();
    send_frame(8'hA5, 8'h5A, 1, 1'b0);
    wait_drained();
  endtask

  // Change both registers after the version byte; CRC keeps the received one
  task automatic test_config_mid_frame();
    logic [7:0]  old_ver;
    logic [15:0] c;
    old_ver = cur_version;
    send_byte(cur_head);
    send_byte(old_ver);
    wait_drained();
    set_registers(8'hC3, 8'h3C);
    c = crc_fold(crc_fold(crc_fold(crc_fold(urx_pkg::CRC_START, old_ver), 8'h81), 8'h7E),
                 8'h00);
    send_byte(8'h81);
    send_byte(8'h7E);
    send_byte(8'h00);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    wait_drained();
  endtask

  // Stall the receiver while frames pour in; the second payload backs up the input
  task automatic test_receiver_hold_off();
    sender_gaps = 1'b0;
    pop_style = POP_EVERY;
    hold_req = 1'b1;
    send_frame(8'($urandom), 8'($urandom), urx_pkg::MAX_PAYLOAD_DEF, 1'b1);
    send_frame(8'($urandom), 8'($urandom), 8, 1'b1);
    send_frame(8'($urandom), 8'($urandom), 0, 1'b1);
    send_frame(8'($urandom), 8'($urandom), 0, 1'b0);
    wait_drained();
  endtask

  // Random traffic under several register settings, extremes included
  task automatic test_random_settings();
    logic [7:0] heads [4];
    logic [7:0] versions [4];
    heads = '{8'h00, 8'hFF, 8'h00, urx_pkg::HEAD_RESET};
    versions = '{8'hFF, 8'h00, 8'h00, urx_pkg::VERSION_RESET};
    heads[2] = 8'($urandom);
    versions[2] = 8'($urandom);
    for (int k = 0; k < 4; k++) begin
      set_registers(heads[k], versions[k]);
      sender_gaps = (k != 2);
      pop_style = (k == 2) ? POP_EVERY : (k == 1) ? POP_BEAT : POP_COIN;
      run_traffic(TRAFFIC_BYTES);
      wait_drained();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_version_mismatch();
    test_empty_frame();
    test_oversized_length();
    test_bad_crc();
    test_config_mid_frame();
    test_receiver_hold_off();
    test_random_settings();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
